// File: design/gbh_pkg.sv
// gbh_pkg: shared constants, request codes and controller/datapath structs
// for the grid bin histogram block; no dependencies
package gbh_pkg;

  // store sizes
  localparam int MAX_VCUTS  = 16;
  localparam int MAX_HCUTS  = 16;
  localparam int COORD_BITS = 30;
  localparam int COUNT_BITS = 16;

  // derived widths
  localparam int ROW_CELLS = MAX_HCUTS + 1;
  localparam int NUM_CELLS = (MAX_VCUTS + 1) * (MAX_HCUTS + 1);
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int VCNT_W    = $clog2(MAX_VCUTS + 1);
  localparam int HCNT_W    = $clog2(MAX_HCUTS + 1);
  localparam int VIDX_W    = (MAX_VCUTS > 1) ? $clog2(MAX_VCUTS) : 1;
  localparam int HIDX_W    = (MAX_HCUTS > 1) ? $clog2(MAX_HCUTS) : 1;

  // request codes
  localparam logic [1:0] REQ_VCUT   = 2'd0;
  localparam logic [1:0] REQ_HCUT   = 2'd1;
  localparam logic [1:0] REQ_POINT  = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic pt_rd;       // point accepted, read its cell
    logic pt_wr;       // write back incremented cell count
    logic scan_start;  // finish accepted, reset scan counters
    logic scan_rd;     // read and zero one scanned cell
    logic clr_wr;      // clearing pass write
    logic out_load;    // load result register, clear cut counts and overflow
  } gbh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic scan_last;
  } gbh_sts_t;

endpackage

// File: design/gbh_if.sv
// gbh_if: valid/ready channel interfaces for input requests and results
// depends on gbh_pkg
interface gbh_in_if
  import gbh_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;

  modport source (output valid, output req_type, output coord_x, output coord_y,
                  input ready);
  modport sink   (input valid, input req_type, input coord_x, input coord_y,
                  output ready);
endinterface

interface gbh_out_if
  import gbh_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] min_count;
  logic [COUNT_BITS-1:0] max_count;
  logic                  overflow;

  modport source (output valid, output min_count, output max_count, output overflow,
                  input ready);
  modport sink   (input valid, input min_count, input max_count, input overflow,
                  output ready);
endinterface

// File: design/grid_bin_histogram_min_max_top.sv
// channel  | dir | handshake   | payload
// in_ch    | in  | valid/ready | req_type[1:0], coord_x[29:0], coord_y[29:0]
// out_ch   | out | valid/ready | min_count[15:0], max_count[15:0], overflow
//
// after reset a clearing pass zeroes the 289-entry cell ram with in_ch.ready
// low. a point is a cell ram read, then a saturating write back through the
// single write port. a finish scans (nv+1)*(nh+1) cells, one cell per cycle,
// plus any wait for the result register to drain; a new item is taken while
// a result waits on out_ch.
//
// top level: controller and datapath; depends on gbh_pkg, gbh_if, gbh_ctrl, gbh_dp
module grid_bin_histogram_min_max_top
  import gbh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  gbh_in_if.sink   in_ch,
  gbh_out_if.source out_ch
);

  gbh_cmd_t cmd;
  gbh_sts_t sts;

  gbh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  gbh_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_ch.req_type),
    .in_coord_x    (in_ch.coord_x),
    .in_coord_y    (in_ch.coord_y),
    .out_min_count (out_ch.min_count),
    .out_max_count (out_ch.max_count),
    .out_overflow  (out_ch.overflow)
  );

`ifndef ASSERT_OFF
  // write-back only right after a point read
  a_pt_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pt_wr |-> $past(cmd.pt_rd))
    else $error("cell write-back without a preceding point read");

  // result register never overwritten while a result is still pending
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before transfer");

  // a scan only begins after a finish transfer
  a_scan_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd.scan_rd) |-> $past(cmd.scan_start))
    else $error("scan started without a finish transfer");
`endif

endmodule

// File: design/gbh_ram.sv
// gbh_ram: generic single-write, single-read ram with registered read data
// no dependencies
module gbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/gbh_ctrl.sv
// gbh_ctrl: sequencer for clearing pass, point update, finish scan and result
// depends on gbh_pkg
module gbh_ctrl
  import gbh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  gbh_sts_t   sts,
  output gbh_cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_PT_WR    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // commands
  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.pt_rd      = accept && (in_req_type == REQ_POINT);
    cmd.scan_start = accept && (in_req_type == REQ_FINISH);
    cmd.pt_wr      = (state_r == S_PT_WR);
    cmd.scan_rd    = (state_r == S_SCAN);
    cmd.clr_wr     = (state_r == S_CLEAR);
    cmd.out_load   = (state_r == S_DONE) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.pt_rd) state_nxt = S_PT_WR;
        else if (cmd.scan_start) state_nxt = S_SCAN;
      end
      S_PT_WR: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/gbh_dp.sv
// gbh_dp: cut stores, parallel binning, cell count ram, scan min/max and
// result register; depends on gbh_pkg and gbh_ram
module gbh_dp
  import gbh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  gbh_cmd_t              cmd,
  output gbh_sts_t              sts,
  input  logic [1:0]            in_req_type,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  output logic [COUNT_BITS-1:0] out_min_count,
  output logic [COUNT_BITS-1:0] out_max_count,
  output logic                  out_overflow
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COORD_BITS-1:0] vcut_r [MAX_VCUTS];
  logic [COORD_BITS-1:0] hcut_r [MAX_HCUTS];
  logic [VCNT_W-1:0]     vcnt_r, vcnt_nxt;
  logic [HCNT_W-1:0]     hcnt_r, hcnt_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [VCNT_W-1:0]     bin_ix;
  logic [HCNT_W-1:0]     bin_iy;
  logic [CELL_W-1:0]     bin_cell;
  logic [CELL_W-1:0]     pt_addr_r;

  logic [CELL_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic [VCNT_W-1:0]     scan_ix_r, scan_ix_nxt;
  logic [HCNT_W-1:0]     scan_iy_r, scan_iy_nxt;
  logic                  fold_vld_r;
  logic [COUNT_BITS-1:0] acc_min_r, acc_max_r;
  logic [COUNT_BITS-1:0] min_r, max_r;
  logic                  ovf_out_r;

  logic                  ram_wr_en, ram_rd_en;
  logic [CELL_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;
  logic                  cnt_sat;

  // parallel cut compare: count stored cuts strictly below the coordinate
  always_comb begin
    bin_ix = '0;
    for (int i = 0; i < MAX_VCUTS; i++) begin
      bin_ix = bin_ix +
        VCNT_W'((VCNT_W'(i) < vcnt_r) && (vcut_r[i] < in_coord_x));
    end
    bin_iy = '0;
    for (int j = 0; j < MAX_HCUTS; j++) begin
      bin_iy = bin_iy +
        HCNT_W'((HCNT_W'(j) < hcnt_r) && (hcut_r[j] < in_coord_y));
    end
    bin_cell = CELL_W'(bin_ix) * CELL_W'(ROW_CELLS) + CELL_W'(bin_iy);
  end

  // cut store writes
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_req_type == REQ_VCUT) && (vcnt_r < VCNT_W'(MAX_VCUTS))) begin
      vcut_r[vcnt_r[VIDX_W-1:0]] <= in_coord_x;
    end
    if (cmd.accept && (in_req_type == REQ_HCUT) && (hcnt_r < HCNT_W'(MAX_HCUTS))) begin
      hcut_r[hcnt_r[HIDX_W-1:0]] <= in_coord_y;
    end
  end

  assign cnt_sat = (ram_rd_data == COUNT_MAX);

  // cut counts and overflow flag
  always_comb begin
    vcnt_nxt = vcnt_r;
    hcnt_nxt = hcnt_r;
    ovf_nxt  = ovf_r;
    if (cmd.accept && (in_req_type == REQ_VCUT)) begin
      if (vcnt_r < VCNT_W'(MAX_VCUTS)) vcnt_nxt = vcnt_r + VCNT_W'(1);
      else ovf_nxt = 1'b1;
    end
    if (cmd.accept && (in_req_type == REQ_HCUT)) begin
      if (hcnt_r < HCNT_W'(MAX_HCUTS)) hcnt_nxt = hcnt_r + HCNT_W'(1);
      else ovf_nxt = 1'b1;
    end
    if (cmd.pt_wr && cnt_sat) ovf_nxt = 1'b1;
    if (cmd.out_load) begin
      vcnt_nxt = '0;
      hcnt_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // scan and clear address walk
  always_comb begin
    scan_addr_nxt = scan_addr_r;
    scan_ix_nxt   = scan_ix_r;
    scan_iy_nxt   = scan_iy_r;
    if (cmd.scan_start) begin
      scan_addr_nxt = '0;
      scan_ix_nxt   = '0;
      scan_iy_nxt   = '0;
    end else if (cmd.scan_rd) begin
      if (scan_iy_r == hcnt_r) begin
        scan_iy_nxt   = '0;
        scan_ix_nxt   = scan_ix_r + VCNT_W'(1);
        scan_addr_nxt = scan_addr_r + CELL_W'(1) + CELL_W'(MAX_HCUTS) - CELL_W'(hcnt_r);
      end else begin
        scan_iy_nxt   = scan_iy_r + HCNT_W'(1);
        scan_addr_nxt = scan_addr_r + CELL_W'(1);
      end
    end else if (cmd.clr_wr) begin
      scan_addr_nxt = scan_addr_r + CELL_W'(1);
    end
  end

  assign sts.scan_last = (scan_ix_r == vcnt_r) && (scan_iy_r == hcnt_r);
  assign sts.clr_last  = (scan_addr_r == CELL_W'(NUM_CELLS - 1));

  // ram port selection
  always_comb begin
    ram_rd_en   = cmd.pt_rd || cmd.scan_rd;
    ram_rd_addr = cmd.pt_rd ? bin_cell : scan_addr_r;
    ram_wr_en   = cmd.pt_wr || cmd.scan_rd || cmd.clr_wr;
    ram_wr_addr = cmd.pt_wr ? pt_addr_r : scan_addr_r;
    ram_wr_data = '0;
    if (cmd.pt_wr) ram_wr_data = cnt_sat ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);
  end

  gbh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      hcnt_r      <= '0;
      ovf_r       <= 1'b0;
      scan_addr_r <= '0;
      scan_ix_r   <= '0;
      scan_iy_r   <= '0;
      fold_vld_r  <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      hcnt_r      <= hcnt_nxt;
      ovf_r       <= ovf_nxt;
      scan_addr_r <= scan_addr_nxt;
      scan_ix_r   <= scan_ix_nxt;
      scan_iy_r   <= scan_iy_nxt;
      fold_vld_r  <= cmd.scan_rd;
    end
  end

  // point address, min/max fold and result register
  always_ff @(posedge clk) begin
    if (cmd.pt_rd) pt_addr_r <= bin_cell;
    if (cmd.scan_start) begin
      acc_min_r <= COUNT_MAX;
      acc_max_r <= '0;
    end else if (fold_vld_r) begin
      if (ram_rd_data < acc_min_r) acc_min_r <= ram_rd_data;
      if (ram_rd_data > acc_max_r) acc_max_r <= ram_rd_data;
    end
    if (cmd.out_load) begin
      min_r     <= acc_min_r;
      max_r     <= acc_max_r;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_min_count = min_r;
  assign out_max_count = max_r;
  assign out_overflow  = ovf_out_r;

endmodule
